// ===== rtl/rlse_pkg.sv =====
package rlse_pkg;

    // Command codes as carried on the kind field
    typedef enum logic [1:0] {
        OP_SET  = 2'd0,
        OP_FILL = 2'd1,
        OP_DIM  = 2'd2,
        OP_SHOW = 2'd3
    } t_op;

    // Colour slots in sending order
    localparam logic [1:0] SLOT_GREEN = 2'd0;
    localparam logic [1:0] SLOT_RED   = 2'd1;
    localparam logic [1:0] SLOT_BLUE  = 2'd2;

    // Reset values of the code registers
    localparam logic [7:0] ONE_CODE_RST  = 8'd240;
    localparam logic [7:0] ZERO_CODE_RST = 8'd192;

    // Configuration register indexes
    localparam logic CFG_ONE_CODE  = 1'b0;
    localparam logic CFG_ZERO_CODE = 1'b1;

    // Command queue geometry
    localparam int CMDQ_DEPTH = 2;
    localparam int CMDQ_AW    = 1;
    localparam int CMDQ_CW    = 2;

    // Classified command, as queued between front and back
    typedef struct packed {
        t_op        op;
        logic [4:0] idx;        // already range checked for set
        logic [7:0] green;
        logic [7:0] red;
        logic [7:0] blue;
        logic [2:0] shift;
        logic       clear;      // dim by 8 or more
    } t_cmd;

    // Eight code bytes for one colour byte, MSB's code on top
    function automatic logic [63:0] encode_byte(input logic [7:0] v,
                                                input logic [7:0] one_c,
                                                input logic [7:0] zero_c);
        logic [63:0] w;
        w = '0;
        for (int b = 0; b < 8; b++) begin
            w[b*8 +: 8] = v[b] ? one_c : zero_c;
        end
        return w;
    endfunction

    // Dim one colour byte
    function automatic logic [7:0] dim_byte(input logic [7:0] v,
                                            input logic [2:0] sh,
                                            input logic       clr);
        return clr ? 8'd0 : (v >> sh);
    endfunction

endpackage

// ===== rtl/rgb_led_strip_spi_encoder.sv =====
// RGB LED strip encoder, SPI bit-code form. Commands come in on the input
// channel: set one LED, fill every LED and show, dim every colour byte by a
// right shift (8 or more clears), or show. A show sends, for LED 0 upward,
// one 64-bit word per green, red and blue byte, each data bit (MSB first,
// top byte of the word) replaced by the one_code or zero_code byte; the
// final word of a show carries last. The pixel store lives in flip-flops and
// is all zero after reset. A front stage decodes commands into a two-entry
// queue; the back end takes one command per cycle when idle. Set and dim
// update the store and leave the back end idle; fill and show hold it in
// the show state until the final word is loaded into the output register,
// one word per cycle while the output is not stalled. Up to two further
// commands queue behind a running show. Configuration: index 0 is one_code,
// index 1 is zero_code; write only while no command is in flight.
module rgb_led_strip_spi_encoder #(
    parameter int LED_COUNT = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [7:0]  i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_kind,
    input  logic [3:0]  i_led_index,
    input  logic [7:0]  i_red,
    input  logic [7:0]  i_green,
    input  logic [7:0]  i_blue,
    input  logic [7:0]  i_dim_shift,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [63:0] o_code_word,
    output logic [3:0]  o_led_number,
    output logic [1:0]  o_color_slot,
    output logic        o_last
);
    import rlse_pkg::*;

    t_cmd front_cmd;
    t_cmd head_cmd;
    logic push;
    logic pop;
    logic q_full;
    logic q_empty;

    // Command decode and range check
    rlse_front u_front (
        .i_in_valid  (i_in_valid),
        .i_kind      (i_kind),
        .i_led_index (i_led_index),
        .i_red       (i_red),
        .i_green     (i_green),
        .i_blue      (i_blue),
        .i_dim_shift (i_dim_shift),
        .i_q_full    (q_full),
        .i_led_count (5'(LED_COUNT)),
        .o_in_stall  (o_in_stall),
        .o_push      (push),
        .o_cmd       (front_cmd)
    );

    // Queue between decode and execution
    rlse_cmd_q u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .i_pop   (pop),
        .o_cmd   (head_cmd),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    // Pixel store, show walk and encoder
    rlse_back #(
        .LED_COUNT (LED_COUNT)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_cmd        (head_cmd),
        .i_q_empty    (q_empty),
        .o_pop        (pop),
        .i_out_stall  (i_out_stall),
        .o_out_valid  (o_out_valid),
        .o_code_word  (o_code_word),
        .o_led_number (o_led_number),
        .o_color_slot (o_color_slot),
        .o_last       (o_last)
    );

endmodule

// ===== rtl/rlse_front.sv =====
module rlse_front (
    input  logic              i_in_valid,
    input  logic [1:0]        i_kind,
    input  logic [3:0]        i_led_index,
    input  logic [7:0]        i_red,
    input  logic [7:0]        i_green,
    input  logic [7:0]        i_blue,
    input  logic [7:0]        i_dim_shift,
    input  logic              i_q_full,
    input  logic [4:0]        i_led_count,
    output logic              o_in_stall,
    output logic              o_push,
    output rlse_pkg::t_cmd    o_cmd
);
    import rlse_pkg::*;

    logic keep;

    // Classify: decode the kind, pre-decode the dim, drop bad set indexes
    always_comb begin
        o_cmd.idx   = {1'b0, i_led_index};
        o_cmd.green = i_green;
        o_cmd.red   = i_red;
        o_cmd.blue  = i_blue;
        o_cmd.shift = i_dim_shift[2:0];
        o_cmd.clear = |i_dim_shift[7:3];
        keep        = 1'b1;
        case (i_kind)
            OP_SET: begin
                o_cmd.op = OP_SET;
                keep     = ({1'b0, i_led_index} < i_led_count);
            end
            OP_FILL: o_cmd.op = OP_FILL;
            OP_DIM:  o_cmd.op = OP_DIM;
            default: o_cmd.op = OP_SHOW;
        endcase
    end

    assign o_in_stall = i_q_full;
    assign o_push     = i_in_valid && !i_q_full && keep;

endmodule

// ===== rtl/rlse_cmd_q.sv =====
module rlse_cmd_q (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  rlse_pkg::t_cmd    i_cmd,
    input  logic              i_pop,
    output rlse_pkg::t_cmd    o_cmd,
    output logic              o_full,
    output logic              o_empty
);
    import rlse_pkg::*;

    t_cmd                r_mem [CMDQ_DEPTH];
    logic [CMDQ_AW-1:0]  r_wr_ptr, n_wr_ptr;
    logic [CMDQ_AW-1:0]  r_rd_ptr, n_rd_ptr;
    logic [CMDQ_CW-1:0]  r_count,  n_count;

    assign o_full  = (r_count == CMDQ_CW'(CMDQ_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_cmd   = r_mem[r_rd_ptr];

    // Pointer and fill count update
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

// ===== rtl/rlse_back.sv =====
module rlse_back #(
    parameter int LED_COUNT = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic              i_cfg_index,
    input  logic [7:0]        i_cfg_data,
    input  rlse_pkg::t_cmd    i_cmd,
    input  logic              i_q_empty,
    output logic              o_pop,
    input  logic              i_out_stall,
    output logic              o_out_valid,
    output logic [63:0]       o_code_word,
    output logic [3:0]        o_led_number,
    output logic [1:0]        o_color_slot,
    output logic              o_last
);
    import rlse_pkg::*;

    localparam int LED_W = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_SHOW = 2'b10
    } t_state;

    t_state             r_state, n_state;
    logic [LED_W-1:0]   r_led, n_led;
    logic [1:0]         r_slot, n_slot;
    logic [23:0]        r_store [LED_COUNT];
    logic [23:0]        n_store [LED_COUNT];
    logic [7:0]         r_one_code, r_zero_code;
    logic               r_out_valid, n_out_valid;
    logic [63:0]        r_code_word, n_code_word;
    logic [3:0]         r_led_number, n_led_number;
    logic [1:0]         r_color_slot, n_color_slot;
    logic               r_last, n_last;

    logic               out_free;
    logic [23:0]        pix_in;
    logic [23:0]        pix_rd;
    logic [7:0]         byte_sel;
    logic               word_last;

    assign out_free = !r_out_valid || !i_out_stall;
    assign o_pop    = (r_state == ST_IDLE) && !i_q_empty;
    assign pix_in   = {i_cmd.green, i_cmd.red, i_cmd.blue};
    assign pix_rd   = r_store[r_led];
    assign word_last = (r_led == LED_W'(LED_COUNT - 1)) && (r_slot == SLOT_BLUE);

    // Colour byte for the current slot
    always_comb begin
        case (r_slot)
            SLOT_GREEN: byte_sel = pix_rd[23:16];
            SLOT_RED:   byte_sel = pix_rd[15:8];
            default:    byte_sel = pix_rd[7:0];
        endcase
    end

    // Command execution and show walk
    always_comb begin
        n_state      = r_state;
        n_led        = r_led;
        n_slot       = r_slot;
        n_store      = r_store;
        n_out_valid  = r_out_valid && i_out_stall;
        n_code_word  = r_code_word;
        n_led_number = r_led_number;
        n_color_slot = r_color_slot;
        n_last       = r_last;
        case (r_state)
            ST_IDLE: begin
                if (o_pop) begin
                    case (i_cmd.op)
                        OP_SET: begin
                            n_store[LED_W'(i_cmd.idx)] = pix_in;
                        end
                        OP_FILL: begin
                            for (int i = 0; i < LED_COUNT; i++) begin
                                n_store[i] = pix_in;
                            end
                            n_state = ST_SHOW;
                            n_led   = '0;
                            n_slot  = SLOT_GREEN;
                        end
                        OP_DIM: begin
                            for (int i = 0; i < LED_COUNT; i++) begin
                                n_store[i] = {
                                    dim_byte(r_store[i][23:16], i_cmd.shift, i_cmd.clear),
                                    dim_byte(r_store[i][15:8],  i_cmd.shift, i_cmd.clear),
                                    dim_byte(r_store[i][7:0],   i_cmd.shift, i_cmd.clear)};
                            end
                        end
                        default: begin
                            n_state = ST_SHOW;
                            n_led   = '0;
                            n_slot  = SLOT_GREEN;
                        end
                    endcase
                end
            end
            ST_SHOW: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_code_word  = encode_byte(byte_sel, r_one_code, r_zero_code);
                    n_led_number = 4'(r_led);
                    n_color_slot = r_slot;
                    n_last       = word_last;
                    if (word_last) begin
                        n_state = ST_IDLE;
                    end else if (r_slot == SLOT_BLUE) begin
                        n_slot = SLOT_GREEN;
                        n_led  = r_led + 1'b1;
                    end else begin
                        n_slot = r_slot + 1'b1;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Control, pixel store and code registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_led       <= '0;
            r_slot      <= SLOT_GREEN;
            r_out_valid <= 1'b0;
            r_one_code  <= ONE_CODE_RST;
            r_zero_code <= ZERO_CODE_RST;
            for (int i = 0; i < LED_COUNT; i++) begin
                r_store[i] <= '0;
            end
        end else begin
            r_state     <= n_state;
            r_led       <= n_led;
            r_slot      <= n_slot;
            r_out_valid <= n_out_valid;
            r_store     <= n_store;
            if (i_cfg_we && i_cfg_index == CFG_ONE_CODE) begin
                r_one_code <= i_cfg_data;
            end
            if (i_cfg_we && i_cfg_index == CFG_ZERO_CODE) begin
                r_zero_code <= i_cfg_data;
            end
        end
    end

    // Output payload
    always_ff @(posedge i_clk) begin
        r_code_word  <= n_code_word;
        r_led_number <= n_led_number;
        r_color_slot <= n_color_slot;
        r_last       <= n_last;
    end

    assign o_out_valid  = r_out_valid;
    assign o_code_word  = r_code_word;
    assign o_led_number = r_led_number;
    assign o_color_slot = r_color_slot;
    assign o_last       = r_last;

endmodule

// ===== rtl/rlse_checker.sv =====
module rlse_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_out_stall,
    input logic        o_out_valid,
    input logic [63:0] o_code_word,
    input logic [3:0]  o_led_number,
    input logic [1:0]  o_color_slot,
    input logic        o_last
);
    import rlse_pkg::*;

    // A stalled word stays offered
    a_valid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("output valid dropped under stall");

    // A stalled word keeps its payload
    a_payload_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_code_word) && $stable(o_led_number)
            && $stable(o_color_slot) && $stable(o_last))
        else $error("output payload changed under stall");

    // The final word of a show is always a blue byte
    a_last_blue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_last |-> o_color_slot == SLOT_BLUE)
        else $error("last flagged on a non-blue word");

    // No colour slot beyond blue
    a_slot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_color_slot <= SLOT_BLUE)
        else $error("color slot out of range");

    // Reset empties the output register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

endmodule

bind rgb_led_strip_spi_encoder rlse_checker u_rlse_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_out_stall  (i_out_stall),
    .o_out_valid  (o_out_valid),
    .o_code_word  (o_code_word),
    .o_led_number (o_led_number),
    .o_color_slot (o_color_slot),
    .o_last       (o_last)
);
